@@ sv/tbc_pkg.sv @@
package tbc_pkg;
    localparam int WINDOW_DEFAULT = 16;
    localparam int SAMPLE_W = 16;
    localparam int Q_W = 24;
    localparam int CFG_W = 24;
    localparam logic [2:0] REG_WINDOWS = 3'd0;
    localparam logic [2:0] REG_SLOW    = 3'd1;
    localparam logic [2:0] REG_FAST    = 3'd2;
    localparam logic [2:0] REG_RSIGMA  = 3'd3;
    localparam logic [2:0] REG_MAXSD   = 3'd4;
    localparam logic [2:0] REG_LSIGMA  = 3'd5;
endpackage

@@ sv/touch_baseline_calibrator_top.sv @@
// Touch baseline calibrator. One 16-bit sample per s_axis word, one result word per
// sample on m_axis; the next sample is taken only once the previous result word has
// gone. A sample that does not close a window goes from the accumulate state straight
// to the output register. A sample that closes a window runs a serial sequencer instead:
// the window sum is squared with a bit-serial multiplier (one multiplier bit a cycle,
// ending early when the window sum is small), a restoring divider gives the variance
// quotient and, alongside it, the window mean (one quotient bit a cycle), the square
// root takes one root bit a cycle, and compare, decision, the two blends (skipped when
// the baseline is first set or restarted) and the output register follow.
// Configuration is written on cfg_wr_en / cfg_addr / cfg_wr_data; indexes beyond the
// list are ignored.
module touch_baseline_calibrator_top #(
    parameter int WINDOW = tbc_pkg::WINDOW_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // baseline_mean, baseline_stdev, is_calibrated,
                                        // window_done, restarted, zero pad
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [tbc_pkg::CFG_W-1:0] cfg_wr_data
);
    localparam int FW = $clog2(WINDOW + 1);
    localparam int SW = 16 + $clog2(WINDOW);
    localparam int QW = 32 + $clog2(WINDOW);
    localparam int NW = 2 * SW + 1 + 16;          // numerator width
    localparam int DW = 2 * $clog2(WINDOW) + 1;
    localparam int RB = (NW + 1) / 2;             // root bits
    localparam int VW = 2 * RB;
    localparam logic [DW-1:0] DIVISOR = DW'(WINDOW * (WINDOW - 1));
    localparam logic [FW-1:0] WDIV = FW'(WINDOW);
    localparam int CW = $clog2(NW + 1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001, S_ACC  = 10'b0000000010,
        S_MUL  = 10'b0000000100, S_SPR  = 10'b0000001000,
        S_DIV  = 10'b0000010000, S_SQRT = 10'b0000100000,
        S_CMP  = 10'b0001000000, S_DEC  = 10'b0010000000,
        S_BLND = 10'b0100000000, S_OUT  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [15:0] wcal_reg, rsig_reg, lsig_reg;
    logic [16:0] slow_reg, fast_reg;
    logic [23:0] maxsd_reg;
    logic [SW-1:0] sum_reg;
    logic [QW-1:0] sq_reg;
    logic [15:0] min_reg, max_reg, x_reg;
    logic [FW-1:0] fill_reg;
    logic [23:0] fm_reg, fsd_reg, mean_reg;
    logic [15:0] gcnt_reg;
    logic cal_reg, done_reg, rst_reg;
    logic [NW-1:0] acc_reg, mq_reg;            // multiplier accumulator / multiplicand
    logic [QW+8:0] mb_reg;
    logic [DW:0] rem_reg;
    logic [NW-1:0] mn_reg;                     // mean numerator / quotient
    logic [FW:0] mr_reg;
    logic [CW-1:0] cnt_reg;
    logic [VW-1:0] v_reg;
    logic [RB+1:0] root_reg, srem_reg;
    logic [23:0] sd_reg;
    logic good_reg, lowm_reg;
    logic m_valid_reg;
    logic [55:0] m_data_reg;
    logic [1:0] phase_reg;
    logic [41:0] prod_reg;
    logic [16:0] c_reg;
    logic [41:0] bl_reg;

    assign s_axis_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    wire [DW+1:0] trial = {rem_reg, acc_reg[NW-1]} - {1'b0, DIVISOR};
    wire [FW+1:0] mtrial = {mr_reg, mn_reg[NW-1]} - {1'b0, WDIV};
    wire [RB+3:0] strial = {srem_reg, v_reg[VW-1 -: 2]} - {root_reg, 2'b01};
    wire signed [48:0] fm16 = $signed({9'd0, fm_reg, 16'd0} >>> 8);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = S_ACC;
            S_ACC:  state_next = (fill_reg == FW'(WINDOW - 1)) ? S_MUL : S_OUT;
            S_MUL:  if (mb_reg == '0) state_next = S_SPR;
            S_SPR:  state_next = S_DIV;
            S_DIV:  if (cnt_reg == CW'(NW - 1)) state_next = S_SQRT;
            S_SQRT: if (cnt_reg == CW'(RB - 1)) state_next = S_CMP;
            S_CMP:  state_next = S_DEC;
            S_DEC:  state_next = (fm_reg == '0 && fsd_reg == '0)
                                 || (!cal_reg && !good_reg) || lowm_reg ? S_OUT : S_BLND;
            S_BLND: if (phase_reg == 2'd3) state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wcal_reg <= 16'd10; slow_reg <= 17'd3277; fast_reg <= 17'd32768;
            rsig_reg <= 16'd768; maxsd_reg <= 24'hFFFFFF; lsig_reg <= 16'd768;
            sum_reg <= '0; sq_reg <= '0; min_reg <= 16'hFFFF; max_reg <= '0;
            fill_reg <= '0; fm_reg <= '0; fsd_reg <= '0; gcnt_reg <= '0;
            cal_reg <= 1'b0; m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    tbc_pkg::REG_WINDOWS: wcal_reg  <= cfg_wr_data[15:0];
                    tbc_pkg::REG_SLOW:    slow_reg  <= cfg_wr_data[16:0];
                    tbc_pkg::REG_FAST:    fast_reg  <= cfg_wr_data[16:0];
                    tbc_pkg::REG_RSIGMA:  rsig_reg  <= cfg_wr_data[15:0];
                    tbc_pkg::REG_MAXSD:   maxsd_reg <= cfg_wr_data[23:0];
                    tbc_pkg::REG_LSIGMA:  lsig_reg  <= cfg_wr_data[15:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_axis_tready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    x_reg <= s_axis_tdata;
                    done_reg <= 1'b0; rst_reg <= 1'b0;
                end
                S_ACC: begin
                    sum_reg <= sum_reg + SW'(x_reg);
                    sq_reg <= sq_reg + QW'(x_reg * x_reg);
                    if (x_reg < min_reg) min_reg <= x_reg;
                    if (x_reg > max_reg) max_reg <= x_reg;
                    fill_reg <= fill_reg + 1'b1;
                    // sum squared by the serial multiply; mean numerator for the divider
                    mq_reg <= NW'(sum_reg + SW'(x_reg));
                    mb_reg <= (QW+9)'(sum_reg + SW'(x_reg));
                    acc_reg <= NW'(WINDOW) * NW'(sq_reg + QW'(x_reg * x_reg));
                    mn_reg <= NW'({sum_reg + SW'(x_reg), 8'd0}) + NW'(WINDOW / 2);
                end
                S_MUL: begin
                    // acc -= sum*sum, one multiplier bit a cycle
                    if (mb_reg[0]) acc_reg <= acc_reg - mq_reg;
                    mq_reg <= mq_reg << 1;
                    mb_reg <= mb_reg >> 1;
                end
                S_SPR: begin
                    acc_reg <= acc_reg << 16;
                    rem_reg <= '0; mr_reg <= '0; cnt_reg <= '0;
                end
                S_DIV: begin
                    if (!trial[DW+1]) rem_reg <= trial[DW:0];
                    else rem_reg <= {rem_reg[DW-1:0], acc_reg[NW-1]};
                    acc_reg <= {acc_reg[NW-2:0], ~trial[DW+1]};
                    if (!mtrial[FW+1]) mr_reg <= mtrial[FW:0];
                    else mr_reg <= {mr_reg[FW-1:0], mn_reg[NW-1]};
                    mn_reg <= {mn_reg[NW-2:0], ~mtrial[FW+1]};
                    cnt_reg <= (cnt_reg == CW'(NW - 1)) ? '0 : cnt_reg + 1'b1;
                    if (cnt_reg == CW'(NW - 1)) begin
                        v_reg <= VW'({acc_reg[NW-2:0], ~trial[DW+1]});
                        mean_reg <= 24'({mn_reg[NW-2:0], ~mtrial[FW+1]});
                        root_reg <= '0; srem_reg <= '0;
                    end
                end
                S_SQRT: begin
                    if (!strial[RB+3]) begin
                        srem_reg <= strial[RB+1:0];
                        root_reg <= {root_reg[RB:0], 1'b1};
                    end else begin
                        srem_reg <= {srem_reg[RB-1:0], v_reg[VW-1 -: 2]};
                        root_reg <= {root_reg[RB:0], 1'b0};
                    end
                    v_reg <= v_reg << 2;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                S_CMP: begin
                    sd_reg <= 24'(root_reg);
                    good_reg <= ({24'd0, root_reg} <= {26'd0, maxsd_reg})
                        && $signed({17'd0, min_reg, 16'd0}) >=
                           fm16 - $signed({9'd0, 40'(rsig_reg * fsd_reg)})
                        && $signed({17'd0, max_reg, 16'd0}) <=
                           fm16 + $signed({9'd0, 40'(rsig_reg * fsd_reg)});
                    lowm_reg <= $signed({17'd0, mean_reg, 8'd0}) <
                           fm16 - $signed({9'd0, 40'(lsig_reg * fsd_reg)});
                    sum_reg <= '0; sq_reg <= '0; min_reg <= 16'hFFFF;
                    max_reg <= '0; fill_reg <= '0; done_reg <= 1'b1;
                    c_reg <= cal_reg ? slow_reg : fast_reg;
                end
                S_DEC: begin
                    phase_reg <= '0;
                    if (c_reg > 17'd65536) c_reg <= 17'd65536;
                    if (fm_reg == '0 && fsd_reg == '0) begin
                        fm_reg <= mean_reg; fsd_reg <= sd_reg;
                    end else if ((!cal_reg && !good_reg) || lowm_reg) begin
                        rst_reg <= 1'b1; gcnt_reg <= '0; cal_reg <= 1'b0;
                        if (mean_reg < fm_reg) fm_reg <= mean_reg;
                        if (sd_reg < fsd_reg) fsd_reg <= sd_reg;
                    end
                end
                S_BLND: begin
                    phase_reg <= phase_reg + 1'b1;
                    unique case (phase_reg)
                        2'd0: begin
                            prod_reg <= 42'(mean_reg * c_reg);
                            bl_reg <= 42'(fm_reg * (17'd65536 - c_reg)) + 42'd32768;
                        end
                        2'd1: begin
                            fm_reg <= 24'((prod_reg + bl_reg) >> 16);
                            prod_reg <= 42'(sd_reg * c_reg);
                            bl_reg <= 42'(fsd_reg * (17'd65536 - c_reg)) + 42'd32768;
                        end
                        2'd2: begin
                            fsd_reg <= 24'((prod_reg + bl_reg) >> 16);
                            if (gcnt_reg != 16'hFFFF) gcnt_reg <= gcnt_reg + 1'b1;
                        end
                        2'd3: if (!cal_reg && gcnt_reg > wcal_reg) cal_reg <= 1'b1;
                        default: ;
                    endcase
                end
                S_OUT: begin
                    m_valid_reg <= 1'b1;
                    m_data_reg <= {5'd0, rst_reg, done_reg, cal_reg, fsd_reg, fm_reg};
                end
                default: ;
            endcase
        end
    end
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    localparam int WIN = tbc_pkg::WINDOW_DEFAULT;
    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        restarted;
        logic        window_done;
        logic        is_calibrated;
        logic [23:0] stdev;
        logic [23:0] mean;
    } baseline_t;

    typedef struct {
        logic [15:0] sample;
        bit          typed;
        baseline_t   want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [tbc_pkg::CFG_W-1:0] cfg_wr_data;

    touch_baseline_calibrator_top #(.WINDOW(WIN)) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    // predictor copy of the registers and state
    logic [15:0] cal_windows;
    logic [16:0] slow_coef;
    logic [16:0] fast_coef;
    logic [15:0] restart_factor;
    logic [23:0] max_sd;
    logic [15:0] low_factor;
    logic [19:0] acc_sum;
    logic [35:0] acc_sq;
    logic [15:0] acc_min;
    logic [15:0] acc_max;
    logic [4:0]  acc_fill;
    logic [23:0] base_mean;
    logic [23:0] base_sd;
    logic [15:0] good_count;
    logic        calibrated;

    baseline_t pending_results[$];
    int mismatches;
    int words_in;
    int words_out;
    int windows_closed;
    int restarts_seen;
    int calibrated_seen;
    bit quiet;
    longint cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned mix(longint unsigned fresh, longint unsigned old,
                                            longint unsigned c);
        if (c > 65536) c = 65536;
        return (fresh * c + old * (65536 - c) + 32768) >> 16;
    endfunction

    function automatic baseline_t baseline_predict(logic [15:0] x);
        baseline_t r;
        longint unsigned s, mean, spread, var_q, sd, c;
        longint fm16, sig, low;
        bit good, low_mean;
        r = '0;
        acc_sum = acc_sum + 20'(x);
        acc_sq = acc_sq + 36'(x) * 36'(x);
        if (x < acc_min) acc_min = x;
        if (x > acc_max) acc_max = x;
        acc_fill = acc_fill + 5'd1;
        if (acc_fill >= WIN) begin
            s = acc_sum;
            mean = (s * 256 + WIN / 2) / WIN;
            spread = WIN * longint'(acc_sq) - s * s;
            var_q = (spread << 16) / (WIN * (WIN - 1));
            sd = isqrt(var_q);
            r.window_done = 1'b1;
            if (base_mean == 0 && base_sd == 0) begin
                base_mean = mean[23:0];
                base_sd = sd[23:0];
            end else begin
                fm16 = longint'(base_mean) << 8;
                sig = longint'(restart_factor) * longint'(base_sd);
                low = longint'(low_factor) * longint'(base_sd);
                good = sd <= max_sd && (longint'(acc_min) << 16) >= fm16 - sig
                       && (longint'(acc_max) << 16) <= fm16 + sig;
                low_mean = longint'(mean << 8) < fm16 - low;
                if ((!calibrated && !good) || low_mean) begin
                    r.restarted = 1'b1;
                    good_count = 0;
                    calibrated = 1'b0;
                    if (mean < base_mean) base_mean = mean[23:0];
                    if (sd < base_sd) base_sd = sd[23:0];
                end else begin
                    c = calibrated ? slow_coef : fast_coef;
                    base_mean = 24'(mix(mean, base_mean, c));
                    base_sd = 24'(mix(sd, base_sd, c));
                    if (good_count != 16'hFFFF) good_count = good_count + 16'd1;
                    if (!calibrated && good_count > cal_windows) calibrated = 1'b1;
                end
            end
            acc_sum = 0;
            acc_sq = 0;
            acc_min = 16'hFFFF;
            acc_max = 0;
            acc_fill = 0;
        end
        r.mean = base_mean;
        r.stdev = base_sd;
        r.is_calibrated = calibrated;
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [23:0] got, logic [23:0] want);
        $display("mismatch at word %0d: %s got %0h want %0h", words_out, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        baseline_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = baseline_t'(m_axis_tdata[50:0]);
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected word", got.mean, 24'h0);
            end else begin
                want = pending_results.pop_front();
                if (got.mean != want.mean) flag_mismatch("mean", got.mean, want.mean);
                if (got.stdev != want.stdev) flag_mismatch("stdev", got.stdev, want.stdev);
                if (got.is_calibrated != want.is_calibrated)
                    flag_mismatch("calibrated", 24'(got.is_calibrated),
                                  24'(want.is_calibrated));
                if (got.window_done != want.window_done)
                    flag_mismatch("window_done", 24'(got.window_done),
                                  24'(want.window_done));
                if (got.restarted != want.restarted)
                    flag_mismatch("restarted", 24'(got.restarted), 24'(want.restarted));
                if (got.window_done) windows_closed++;
                if (got.restarted) restarts_seen++;
                if (got.is_calibrated) calibrated_seen++;
            end
            words_out++;
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 7);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     pending_results.size());
            $display("** touch_baseline_calibrator_top: FAILED **");
            $finish;
        end
    end

    task automatic send_sample(logic [15:0] x, bit typed, baseline_t want);
        baseline_t p;
        if (!quiet && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= x;
        do @(posedge aclk); while (!s_axis_tready);
        p = baseline_predict(x);
        pending_results.insert(pending_results.size(), typed ? want : p);
        words_in++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [tbc_pkg::CFG_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= v;
        @(posedge aclk);
        case (idx)
            tbc_pkg::REG_WINDOWS: cal_windows = v[15:0];
            tbc_pkg::REG_SLOW:    slow_coef = v[16:0];
            tbc_pkg::REG_FAST:    fast_coef = v[16:0];
            tbc_pkg::REG_RSIGMA:  restart_factor = v[15:0];
            tbc_pkg::REG_MAXSD:   max_sd = v[23:0];
            tbc_pkg::REG_LSIGMA:  low_factor = v[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [15:0] clamp16(int v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    task automatic send_window();
        int mode, level, noise, n;
        logic [15:0] fixed_val;
        mode = $urandom_range(99);
        level = int'(base_mean >> 8);
        noise = int'(base_sd >> 8) + 2;
        if (level == 0) level = $urandom_range(200, 60000);
        fixed_val = 16'($urandom);
        n = WIN - int'(acc_fill);
        repeat (n) begin
            logic [15:0] x;
            if (mode < 55)
                x = clamp16(level + int'($urandom_range(0, 2 * noise)) - noise);
            else if (mode < 65)
                x = clamp16(level / 2 + int'($urandom_range(0, noise)));
            else if (mode < 70)
                x = 16'd0;
            else if (mode < 85)
                x = 16'($urandom);
            else
                x = fixed_val;
            send_sample(x, 1'b0, '0);
        end
    endtask

    stim_row_t dir_rows[24];
    logic [15:0] dir_samples[24] = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001,
        16'h8000, 16'h7FFF, 16'hFFFE, 16'h00FF, 16'hFF00, 16'h1234, 16'h0F0F, 16'hF0F0,
        16'h3333, 16'hCCCC, 16'h4000, 16'h4000, 16'h4001, 16'h3FFF, 16'h0000, 16'hFFFF,
        16'h4000, 16'h4002, 16'h3FFE};

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wr_data = '0;
        quiet = 1'b0;
        mismatches = 0;
        words_in = 0;
        words_out = 0;
        windows_closed = 0;
        restarts_seen = 0;
        calibrated_seen = 0;
        cycles = 0;
        cal_windows = 16'd10;
        slow_coef = 17'd3277;
        fast_coef = 17'd32768;
        restart_factor = 16'd768;
        max_sd = 24'hFFFFFF;
        low_factor = 16'd768;
        acc_sum = 0;
        acc_sq = 0;
        acc_min = 16'hFFFF;
        acc_max = 0;
        acc_fill = 0;
        base_mean = 0;
        base_sd = 0;
        good_count = 0;
        calibrated = 1'b0;

        // baseline stays zero until the first window closes
        foreach (dir_rows[i]) begin
            dir_rows[i].sample = dir_samples[i];
            dir_rows[i].typed = (i < WIN - 1);
            dir_rows[i].want = '0;
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_sample(dir_rows[i].sample, dir_rows[i].typed,
                                          dir_rows[i].want);

        for (int phase = 0; phase < 7; phase++) begin
            drain();
            case (phase)
                0: ;
                1: begin
                    write_reg(tbc_pkg::REG_WINDOWS, 24'd0);
                    write_reg(tbc_pkg::REG_SLOW, 24'd65536);
                    write_reg(tbc_pkg::REG_FAST, 24'h1FFFF);
                    write_reg(tbc_pkg::REG_RSIGMA, 24'd65535);
                    write_reg(tbc_pkg::REG_MAXSD, 24'hFFFFFF);
                    write_reg(tbc_pkg::REG_LSIGMA, 24'd65535);
                end
                2: begin
                    write_reg(tbc_pkg::REG_WINDOWS, 24'd65535);
                    write_reg(tbc_pkg::REG_SLOW, 24'd0);
                    write_reg(tbc_pkg::REG_FAST, 24'd0);
                    write_reg(tbc_pkg::REG_RSIGMA, 24'd0);
                    write_reg(tbc_pkg::REG_MAXSD, 24'd0);
                    write_reg(tbc_pkg::REG_LSIGMA, 24'd0);
                    write_reg(REG_UNUSED, 24'hFFFFFF);
                end
                3: begin
                    write_reg(tbc_pkg::REG_WINDOWS, 24'd65534);
                    write_reg(tbc_pkg::REG_FAST, 24'd65536);
                    write_reg(tbc_pkg::REG_RSIGMA, 24'd768);
                    write_reg(tbc_pkg::REG_MAXSD, 24'hFFFFFF);
                    write_reg(tbc_pkg::REG_LSIGMA, 24'd768);
                    write_reg(REG_UNUSED_HI, 24'h000001);
                end
                default: begin
                    write_reg(tbc_pkg::REG_WINDOWS, 24'($urandom_range(0, 3)));
                    write_reg(tbc_pkg::REG_SLOW, 24'($urandom_range(0, 131071)));
                    write_reg(tbc_pkg::REG_FAST, 24'($urandom_range(0, 131071)));
                    write_reg(tbc_pkg::REG_RSIGMA, 24'($urandom_range(128, 4096)));
                    write_reg(tbc_pkg::REG_MAXSD, $urandom_range(0, 3) == 0
                                                  ? 24'($urandom_range(0, 4095))
                                                  : 24'hFFFFFF);
                    write_reg(tbc_pkg::REG_LSIGMA, 24'($urandom_range(0, 65535)));
                end
            endcase
            cfg_wr_en <= 1'b0;
            @(posedge aclk);
            // one phase runs with no idling on either side
            quiet = (phase == 4);
            repeat (6) send_window();
        end
        quiet = 1'b0;

        drain();
        repeat (40) @(posedge aclk);
        $display("%0d samples sent, %0d words checked over 7 register settings", words_in,
                 words_out);
        $display("%0d windows closed, %0d restarts, %0d words while calibrated",
                 windows_closed, restarts_seen, calibrated_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("** touch_baseline_calibrator_top: PASSED **");
        end else begin
            $display("** touch_baseline_calibrator_top: FAILED **");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
sv/tbc_pkg.sv
sv/touch_baseline_calibrator_top.sv
tb/tb_top.sv
